>>> hw/rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// shared types and constants of the chebyshev series evaluator
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int DATA_W = 32;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_SAT  = 2'd1;
    localparam logic [1:0] STATUS_SPAN = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LOWER = 2'd0;
    localparam logic [1:0] CFG_UPPER = 2'd1;
    localparam logic [1:0] CFG_ORDER = 2'd2;

    localparam logic signed [DATA_W-1:0] LOWER_RST = -32'sd65536;
    localparam logic signed [DATA_W-1:0] UPPER_RST = 32'sd65536;
    localparam logic [4:0]               ORDER_RST = 5'd16;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                     operation;
        logic [3:0]               coeff_index;
        logic signed [DATA_W-1:0] coeff_value;
        logic signed [DATA_W-1:0] point;
        logic                     last_point;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [1:0]               status;
        logic                     batch_end;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } t_state;

    // divider status toward the sequencer
    typedef struct packed {
        logic done;
        logic sat;
    } t_div_stat;

    // recurrence datapath controls
    typedef struct packed {
        logic clear;
        logic mul;
        logic add;
        logic last;
    } t_clen_ctrl;

endpackage

>>> hw/rtl/cse_ram.sv
// ----------------------------------------------------------------------------
// cse_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module cse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/cse_div.sv
// ----------------------------------------------------------------------------
// cse_div
// radix-4 restoring divider that maps a point onto [-1,1] in Q16.16
// ----------------------------------------------------------------------------
module cse_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [34:0]   i_num,
    input  logic signed [32:0]   i_den,
    output cse_pkg::t_div_stat   o_stat,
    output logic signed [31:0]   o_y
);

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [32:0] r_rem;
    logic [32:0] r_dvs;
    logic [31:0] r_dnd;
    logic [31:0] r_quot;
    logic        r_neg;
    logic        r_ovf;

    logic [34:0] w_num_mag;
    logic [32:0] w_den_mag;
    logic [49:0] w_dividend;
    logic [32:0] w_hi;
    logic        w_ovf;
    logic [33:0] w_t1;
    logic [33:0] w_t2;
    logic        w_ge1;
    logic        w_ge2;
    logic [32:0] w_r1;
    logic [32:0] w_r2;
    logic        w_sat;

    assign w_num_mag  = i_num[34] ? 35'(-i_num) : 35'(i_num);
    assign w_den_mag  = i_den[32] ? 33'(-i_den) : 33'(i_den);
    assign w_dividend = {w_num_mag[33:0], 16'd0};
    assign w_hi       = {15'd0, w_dividend[49:32]};
    // quotient needs more than 32 bits
    assign w_ovf      = (w_hi >= w_den_mag);

    // two restoring steps per cycle
    assign w_t1  = {r_rem, r_dnd[31]};
    assign w_ge1 = (w_t1 >= {1'b0, r_dvs});
    assign w_r1  = w_ge1 ? 33'(w_t1 - {1'b0, r_dvs}) : w_t1[32:0];
    assign w_t2  = {w_r1, r_dnd[30]};
    assign w_ge2 = (w_t2 >= {1'b0, r_dvs});
    assign w_r2  = w_ge2 ? 33'(w_t2 - {1'b0, r_dvs}) : w_t2[32:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == 4'd15);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= w_ovf ? '0 : w_hi;
            r_dvs  <= w_den_mag;
            r_dnd  <= w_dividend[31:0];
            r_quot <= '0;
            r_neg  <= i_num[34] ^ i_den[32];
            r_ovf  <= w_ovf;
        end else if (r_busy) begin
            r_rem  <= w_r2;
            r_dnd  <= {r_dnd[29:0], 2'b00};
            r_quot <= {r_quot[29:0], w_ge1, w_ge2};
        end
    end

    // sign and saturation of the magnitude quotient
    always_comb begin
        if (r_neg) begin
            w_sat = r_ovf || (r_quot > 32'h8000_0000);
            o_y   = w_sat ? cse_pkg::Q_MIN : 32'(-r_quot);
        end else begin
            w_sat = r_ovf || r_quot[31];
            o_y   = w_sat ? cse_pkg::Q_MAX : r_quot;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.sat  = w_sat;

endmodule

>>> hw/rtl/cse_clen.sv
// ----------------------------------------------------------------------------
// cse_clen
// clenshaw recurrence datapath: registered multiply, then add and saturate
// ----------------------------------------------------------------------------
module cse_clen (
    input  logic                 i_clk,
    input  cse_pkg::t_clen_ctrl  i_ctrl,
    input  logic signed [31:0]   i_y,
    input  logic signed [31:0]   i_coef,
    output logic signed [31:0]   o_acc,
    output logic                 o_sat
);

    logic signed [31:0] r_d1;
    logic signed [31:0] r_d2;
    logic signed [63:0] r_prod;
    logic               r_sat;

    logic signed [63:0] w_shift;
    logic signed [31:0] w_coef;
    logic signed [51:0] w_sum;
    logic               w_ovf;
    logic signed [31:0] w_sat_val;

    // final step doubles nothing and halves c0
    assign w_shift = i_ctrl.last ? (r_prod >>> 16) : (r_prod >>> 15);
    assign w_coef  = i_ctrl.last ? (i_coef >>> 1) : i_coef;
    assign w_sum   = w_shift[51:0] - {{20{r_d2[31]}}, r_d2}
                   + {{20{w_coef[31]}}, w_coef};
    assign w_ovf   = !((&w_sum[51:31]) || !(|w_sum[51:31]));

    always_comb begin
        if (!w_ovf) begin
            w_sat_val = w_sum[31:0];
        end else if (w_sum[51]) begin
            w_sat_val = cse_pkg::Q_MIN;
        end else begin
            w_sat_val = cse_pkg::Q_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_d1  <= '0;
            r_d2  <= '0;
            r_sat <= 1'b0;
        end else if (i_ctrl.add) begin
            r_d1  <= w_sat_val;
            r_d2  <= r_d1;
            r_sat <= r_sat | w_ovf;
        end
        if (i_ctrl.mul) begin
            r_prod <= i_y * r_d1;
        end
    end

    assign o_acc = r_d1;
    assign o_sat = r_sat;

endmodule

>>> hw/rtl/chebyshev_series_evaluator.sv
// ----------------------------------------------------------------------------
// chebyshev_series_evaluator
// chebyshev series evaluation by clenshaw recurrence, signed q16.16
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  command   in   start, busy (start & !busy)  i_cmd    (cse_pkg::t_cmd)
//  result    out  o_result_valid, one cycle    o_result (cse_pkg::t_result)
//  config    in   i_cfg_we                     i_cfg_addr, i_cfg_wdata
//
//  a load transfer gives no result and leaves the block idle
//  an evaluate transfer runs the radix-4 divider, then one multiply and one
//  add per coefficient of the effective series order through the single
//  multiplier and adder loop
//  a zero domain span gives its result in the cycle after the transfer
//  the next command is taken in the cycle its predecessor's result is shown
//  reset is synchronous; the coefficient store reads as zero until written
//  the receiver cannot stall, so a result is never held
// ----------------------------------------------------------------------------
module chebyshev_series_evaluator #(
    parameter int MAX_ORDER = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  cse_pkg::t_cmd     i_cmd,
    output logic              o_result_valid,
    output cse_pkg::t_result  o_result,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_addr,
    input  logic [31:0]       i_cfg_wdata
);

    localparam int KW = $clog2(MAX_ORDER);
    localparam int CW = (KW + 1 > 5) ? KW + 1 : 5;

    // configuration
    logic signed [31:0] r_lower;
    logic signed [31:0] r_upper;
    logic [4:0]         r_order;

    // sequencer
    cse_pkg::t_state    r_state;
    cse_pkg::t_state    n_state;
    logic [KW-1:0]      r_k;
    logic [MAX_ORDER-1:0] r_valid;
    logic               r_vld_rd;
    logic               r_last;
    logic               r_out_vld;
    cse_pkg::t_result   r_out;

    logic               w_accept;
    logic               w_load;
    logic               w_eval;
    logic               w_ld_ok;
    logic [KW+3:0]      w_idx_ext;
    logic signed [34:0] w_num;
    logic signed [32:0] w_den;
    logic               w_span_zero;
    logic               w_div_start;
    cse_pkg::t_div_stat w_div_stat;
    logic signed [31:0] w_y;
    cse_pkg::t_clen_ctrl w_ctrl;
    logic [31:0]        w_rdata;
    logic signed [31:0] w_coef;
    logic signed [31:0] w_acc;
    logic               w_clen_sat;
    logic [CW-1:0]      w_ord_ext;
    logic [CW-1:0]      w_ord_clip;
    logic [CW-1:0]      w_kstart;

    assign busy     = (r_state != cse_pkg::ST_IDLE);
    assign w_accept = start && !busy;
    assign w_load   = w_accept && (i_cmd.operation == cse_pkg::OP_LOAD);
    assign w_eval   = w_accept && (i_cmd.operation == cse_pkg::OP_EVAL);

    // loads beyond the store are dropped
    assign w_ld_ok   = (32'(i_cmd.coeff_index) < MAX_ORDER);
    assign w_idx_ext = {{KW{1'b0}}, i_cmd.coeff_index};

    // numerator 2x - a - b and span b - a
    assign w_num = {{2{i_cmd.point[31]}}, i_cmd.point, 1'b0}
                 - {{3{r_lower[31]}}, r_lower}
                 - {{3{r_upper[31]}}, r_upper};
    assign w_den = {r_upper[31], r_upper} - {r_lower[31], r_lower};
    assign w_span_zero = (w_den == '0);
    assign w_div_start = w_eval && !w_span_zero;

    // order clamped to the store, order zero runs as order one
    assign w_ord_ext  = CW'(r_order);
    assign w_ord_clip = (w_ord_ext > CW'(MAX_ORDER)) ? CW'(MAX_ORDER) : w_ord_ext;
    assign w_kstart   = (w_ord_clip == '0) ? '0 : w_ord_clip - CW'(1);

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= cse_pkg::LOWER_RST;
            r_upper <= cse_pkg::UPPER_RST;
            r_order <= cse_pkg::ORDER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                cse_pkg::CFG_LOWER: r_lower <= i_cfg_wdata;
                cse_pkg::CFG_UPPER: r_upper <= i_cfg_wdata;
                cse_pkg::CFG_ORDER: r_order <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // coefficient store, entries not yet written read as zero
    cse_ram #(
        .WIDTH (32),
        .DEPTH (MAX_ORDER)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_load && w_ld_ok),
        .i_waddr (w_idx_ext[KW-1:0]),
        .i_wdata (i_cmd.coeff_value),
        .i_raddr (r_k),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_load && w_ld_ok) begin
            r_valid[w_idx_ext[KW-1:0]] <= 1'b1;
        end
    end

    // valid bit is registered from the same read address, like the ram data
    always_ff @(posedge i_clk) begin
        r_vld_rd <= r_valid[r_k];
    end

    assign w_coef = r_vld_rd ? w_rdata : '0;

    cse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_stat  (w_div_stat),
        .o_y     (w_y)
    );

    cse_clen u_clen (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_y    (w_y),
        .i_coef (w_coef),
        .o_acc  (w_acc),
        .o_sat  (w_clen_sat)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cse_pkg::ST_IDLE: begin
                if (w_div_start) begin
                    n_state = cse_pkg::ST_DIV;
                end
            end
            cse_pkg::ST_DIV: begin
                if (w_div_stat.done) begin
                    n_state = cse_pkg::ST_MUL;
                end
            end
            cse_pkg::ST_MUL: n_state = cse_pkg::ST_ADD;
            cse_pkg::ST_ADD: begin
                if (r_k == '0) begin
                    n_state = cse_pkg::ST_DONE;
                end else begin
                    n_state = cse_pkg::ST_MUL;
                end
            end
            cse_pkg::ST_DONE: n_state = cse_pkg::ST_IDLE;
            default: n_state = cse_pkg::ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        w_ctrl = '0;
        case (r_state)
            cse_pkg::ST_DIV: w_ctrl.clear = w_div_stat.done;
            cse_pkg::ST_MUL: w_ctrl.mul   = 1'b1;
            cse_pkg::ST_ADD: begin
                w_ctrl.add  = 1'b1;
                w_ctrl.last = (r_k == '0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cse_pkg::ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= (r_state == cse_pkg::ST_DONE) || (w_eval && w_span_zero);
        end
    end

    // coefficient walk from the top order down to c0
    always_ff @(posedge i_clk) begin
        if (r_state == cse_pkg::ST_DIV && w_div_stat.done) begin
            r_k <= w_kstart[KW-1:0];
        end else if (r_state == cse_pkg::ST_ADD && r_k != '0) begin
            r_k <= r_k - KW'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_eval) begin
            r_last <= i_cmd.last_point;
        end
        if (w_eval && w_span_zero) begin
            r_out.value     <= '0;
            r_out.status    <= cse_pkg::STATUS_SPAN;
            r_out.batch_end <= i_cmd.last_point;
        end else if (r_state == cse_pkg::ST_DONE) begin
            r_out.value     <= w_acc;
            r_out.status    <= (w_div_stat.sat || w_clen_sat) ?
                               cse_pkg::STATUS_SAT : cse_pkg::STATUS_OK;
            r_out.batch_end <= r_last;
        end
    end

    assign o_result_valid = r_out_vld;
    assign o_result       = r_out;

    // a result only follows the end of a walk or a zero span transfer
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == cse_pkg::ST_DONE) || $past(start && !busy))
        else $error("result without a finished evaluation");

    // the walk index stays inside the store
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cse_pkg::ST_MUL) |-> (32'(r_k) < MAX_ORDER))
        else $error("coefficient index outside the store");

    // divider completes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == cse_pkg::ST_DIV))
        else $error("divider done outside the divide phase");

    // zero span results carry a zero value
    a_span_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status == cse_pkg::STATUS_SPAN)
            |-> (o_result.value == '0))
        else $error("zero span result with nonzero value");

endmodule

>>> verif/chebyshev_series_evaluator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chebyshev_series_evaluator_tb
// self-checking bench for the chebyshev series evaluator: loads and
// evaluate commands go through the start/busy handshake, a clenshaw
// predictor in q16.16 computes each expected result, and a checker
// compares every result strobe field by field with the oldest expectation
// ----------------------------------------------------------------------------
module chebyshev_series_evaluator_tb;

    localparam int MAX_ORDER = 16;
    // settle margin after the drain; a load gives no result and never raises busy
    localparam int SETTLE_CYCLES = 4;
    // beyond the longest evaluate, at the full store order
    localparam int DRAIN_CYCLES = 60;
    // slowest item plus the longest sender gap, several times over
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TOTAL = 850;
    localparam int PHASE_ITEMS = 80;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    cse_pkg::t_cmd    i_cmd = '0;
    logic             o_result_valid;
    cse_pkg::t_result o_result;
    logic             i_cfg_we = 1'b0;
    logic [1:0]       i_cfg_addr = '0;
    logic [31:0]      i_cfg_wdata = '0;

    // shadow copy of the block's store and registers
    int               coeff_mem [MAX_ORDER];
    int               dom_lo;
    int               dom_hi;
    int unsigned      order_reg;

    cse_pkg::t_result expected_q [$];
    int               error_count = 0;
    int               items_sent = 0;
    int               idle_cycles = 0;
    bit               quick_mode = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    chebyshev_series_evaluator #(
        .MAX_ORDER      (MAX_ORDER)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // clenshaw predictor
    // ------------------------------------------------------------------------
    function automatic longint clamp_q(longint v);
        if (v > Q_HI) return Q_HI;
        if (v < Q_LO) return Q_LO;
        return v;
    endfunction

    function automatic cse_pkg::t_result predict_series(cse_pkg::t_cmd c);
        cse_pkg::t_result r;
        longint  span, num, quo, y, d1, d2, dn, acc;
        int      n;
        bit      sat;
        r.batch_end = c.last_point;
        span = longint'(dom_hi) - longint'(dom_lo);
        if (span == 0) begin
            r.value  = '0;
            r.status = cse_pkg::STATUS_SPAN;
            return r;
        end
        sat = 1'b0;
        // map x onto [-1,1], truncating toward zero
        num = 2 * longint'($signed(c.point)) - longint'(dom_lo) - longint'(dom_hi);
        quo = (num * 64'sd65536) / span;
        y = clamp_q(quo);
        sat |= (y != quo);
        // order zero runs like order one, with only the final step; orders above the store are clamped
        n = (order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
        d1 = 0;
        d2 = 0;
        for (int i = n - 1; i >= 1; i--) begin
            // 2*y*d as a floor shift by 15
            dn = ((y * d1) >>> 15) - d2 + longint'(coeff_mem[i]);
            d2 = d1;
            d1 = clamp_q(dn);
            sat |= (d1 != dn);
        end
        acc = ((y * d1) >>> 16) - d2 + (longint'(coeff_mem[0]) >>> 1);
        quo = clamp_q(acc);
        sat |= (quo != acc);
        r.value  = quo[31:0];
        r.status = sat ? cse_pkg::STATUS_SAT : cse_pkg::STATUS_OK;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // command building, unused fields carry random bits
    // ------------------------------------------------------------------------
    function automatic cse_pkg::t_cmd noise_cmd();
        cse_pkg::t_cmd c;
        c.operation   = $urandom_range(0, 1);
        c.coeff_index = $urandom_range(0, 15);
        c.coeff_value = $urandom;
        c.point       = $urandom;
        c.last_point  = $urandom_range(0, 1);
        return c;
    endfunction

    function automatic cse_pkg::t_cmd load_cmd(logic [3:0] idx, int val);
        cse_pkg::t_cmd c;
        c = noise_cmd();
        c.operation   = cse_pkg::OP_LOAD;
        c.coeff_index = idx;
        c.coeff_value = val;
        return c;
    endfunction

    function automatic cse_pkg::t_cmd eval_cmd(int x, logic last);
        cse_pkg::t_cmd c;
        c = noise_cmd();
        c.operation  = cse_pkg::OP_EVAL;
        c.point      = x;
        c.last_point = last;
        return c;
    endfunction

    // coefficients within about +-2.0, now and then any 32-bit value
    function automatic int rand_coeff();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return int'($urandom_range(0, 1 << 18)) - (1 << 17);
    endfunction

    // ------------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------------
    // one transfer, then a random gap if not quick; start stays high back to back
    task automatic send_item(cse_pkg::t_cmd c);
        int pick, len;
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
        if (c.operation == cse_pkg::OP_EVAL)
            expected_q.push_back(predict_series(c));
        else if (c.coeff_index < MAX_ORDER)
            coeff_mem[c.coeff_index] = c.coeff_value;
        if (!quick_mode) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      len = 0;
            else if (pick < 88) len = $urandom_range(1, 3);
            else if (pick < 97) len = $urandom_range(4, 12);
            else                len = $urandom_range(20, 45);
            if (len > 0) begin
                start <= 1'b0;
                i_cmd <= noise_cmd();
                repeat (len) @(posedge i_clk);
            end
        end
    endtask

    // sender holds off until every expected result has come
    task automatic wait_results_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
    endtask

    // idle point for register writes: results drained and no load in flight
    task automatic settle_block();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // leaves the write enable high so writes can go back to back
    task automatic cfg_write(logic [1:0] addr, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (addr)
            cse_pkg::CFG_LOWER: dom_lo = data;
            cse_pkg::CFG_UPPER: dom_hi = data;
            cse_pkg::CFG_ORDER: order_reg = data[4:0];
            default: ;
        endcase
    endtask

    task automatic configure(int lo, int hi, int unsigned ord);
        settle_block();
        cfg_write(cse_pkg::CFG_LOWER, lo);
        cfg_write(cse_pkg::CFG_UPPER, hi);
        // upper bits of the order write are don't-care, keep them moving
        cfg_write(cse_pkg::CFG_ORDER, (ord & 32'h1f) | ($urandom & 32'hffff_ffe0));
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= $urandom;
    endtask

    // ------------------------------------------------------------------------
    // result checker, results cannot be held off
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        cse_pkg::t_result want;
        if (i_rst_n && o_result_valid) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_result);
                error_count++;
            end else begin
                want = expected_q.pop_front();
                if (o_result.value !== want.value) begin
                    $display("%0t: value mismatch, expected %h, actual %h",
                             $time, want.value, o_result.value);
                    error_count++;
                end
                if (o_result.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, o_result.status);
                    error_count++;
                end
                if (o_result.batch_end !== want.batch_end) begin
                    $display("%0t: batch_end mismatch, expected %b, actual %b",
                             $time, want.batch_end, o_result.batch_end);
                    error_count++;
                end
            end
        end
    end

    // watchdog: cycles with neither a command transfer nor a result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transfer for %0d cycles", $time, idle_cycles);
            $display("chebyshev_series_evaluator_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // empty store after reset, default domain [-1,1]
    task automatic test_reset_state();
        send_item(eval_cmd(0, 1'b0));
        send_item(eval_cmd(cse_pkg::Q_MAX, 1'b0));
        send_item(eval_cmd(cse_pkg::Q_MIN, 1'b1));
    endtask

    // coefficient extremes at both ends of the store, saturating series
    task automatic test_load_extremes();
        send_item(load_cmd(4'd0, cse_pkg::Q_MAX));
        send_item(load_cmd(4'd15, cse_pkg::Q_MIN));
        send_item(load_cmd(4'd1, 32'sh0001_0000));
        send_item(eval_cmd(-65536, 1'b0));
        send_item(eval_cmd(0, 1'b0));
        send_item(eval_cmd(65536, 1'b1));
    endtask

    // order zero acts as one, orders above the store clamp
    task automatic test_order_edges();
        int unsigned ords [4] = '{0, 1, 31, 16};
        foreach (ords[k]) begin
            configure(cse_pkg::LOWER_RST, cse_pkg::UPPER_RST, ords[k]);
            send_item(eval_cmd(32768, k == 3));
        end
    endtask

    // equal bounds give the span error
    task automatic test_zero_span();
        configure(12345, 12345, 16);
        send_item(eval_cmd(12345, 1'b0));
        configure(cse_pkg::Q_MIN, cse_pkg::Q_MIN, 16);
        send_item(eval_cmd(cse_pkg::Q_MAX, 1'b1));
    endtask

    // widest domain both ways round
    task automatic test_domain_extremes();
        configure(cse_pkg::Q_MIN, cse_pkg::Q_MAX, 16);
        send_item(eval_cmd(cse_pkg::Q_MIN, 1'b0));
        send_item(eval_cmd(cse_pkg::Q_MAX, 1'b1));
        configure(cse_pkg::Q_MAX, cse_pkg::Q_MIN, 31);
        send_item(eval_cmd(0, 1'b0));
        send_item(eval_cmd(cse_pkg::Q_MAX, 1'b1));
    endtask

    // a write past the last register changes nothing
    task automatic test_unused_register();
        configure(cse_pkg::LOWER_RST, cse_pkg::UPPER_RST, 16);
        @(posedge i_clk);
        cfg_write(CFG_UNUSED, $urandom);
        i_cfg_we <= 1'b0;
        send_item(eval_cmd(-20000, 1'b1));
    endtask

    // phases of random settings, each a run of load batches and point batches
    task automatic test_random_phases();
        int            kind, quota, n_load, n_pts, lo, hi, base, w, x;
        int unsigned   ord;
        bit            wild;
        cse_pkg::t_cmd c;
        while (items_sent < ITEM_TOTAL) begin
            kind = $urandom_range(0, 9);
            lo   = int'($urandom_range(0, 1 << 21)) - (1 << 20);
            w    = $urandom_range(1, 1 << 21);
            wild = 1'b0;
            if (kind < 6) begin
                hi = lo + w;
                base = lo;
            end else if (kind < 8) begin
                // reversed domain, negative span
                hi = lo;
                lo = lo + w;
                base = hi;
            end else if (kind == 8) begin
                hi = lo;
                base = lo;
            end else begin
                lo = $urandom;
                hi = $urandom;
                base = 0;
                wild = 1'b1;
            end
            case ($urandom_range(0, 9))
                0:       ord = 0;
                1:       ord = $urandom_range(17, 31);
                default: ord = $urandom_range(1, 16);
            endcase
            configure(lo, hi, ord);
            quota = items_sent + PHASE_ITEMS;
            while (items_sent < quota && items_sent < ITEM_TOTAL) begin
                quick_mode = ($urandom_range(0, 3) == 0);
                n_load = $urandom_range(0, 5);
                for (int k = 0; k < n_load; k++) begin
                    if ($urandom_range(0, 9) == 0) c = noise_cmd();
                    else c = load_cmd($urandom_range(0, 15), rand_coeff());
                    send_item(c);
                end
                n_pts = $urandom_range(1, 6);
                for (int k = 0; k < n_pts; k++) begin
                    if (wild || $urandom_range(0, 7) == 0) x = $urandom;
                    else x = base + int'($urandom_range(0, w));
                    if ($urandom_range(0, 9) == 0) c = noise_cmd();
                    else c = eval_cmd(x, k == n_pts - 1);
                    send_item(c);
                end
                // sender pause until the block has answered everything
                if ($urandom_range(0, 7) == 0)
                    wait_results_drained();
            end
        end
        quick_mode = 1'b0;
    endtask

    initial begin
        foreach (coeff_mem[k]) coeff_mem[k] = 0;
        dom_lo    = cse_pkg::LOWER_RST;
        dom_hi    = cse_pkg::UPPER_RST;
        order_reg = cse_pkg::ORDER_RST;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_load_extremes();
        test_order_edges();
        test_zero_span();
        test_domain_extremes();
        test_unused_register();
        test_random_phases();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("chebyshev_series_evaluator_tb: done, clean");
        else
            $display("chebyshev_series_evaluator_tb: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/cse_pkg.sv
hw/rtl/cse_ram.sv
hw/rtl/cse_div.sv
hw/rtl/cse_clen.sv
hw/rtl/chebyshev_series_evaluator.sv
verif/chebyshev_series_evaluator_tb.sv
